FILE: design/hvng_pkg.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normal generator package
// Configuration register layout, register indexes and shared constants.
// ----------------------------------------------------------------------------
package hvng_pkg;

  typedef struct packed {
    logic [8:0] tile_length;
    logic [1:0] lod_shift;
    logic [7:0] tile_grid_x;
    logic [7:0] tile_grid_z;
  } cfg_t;

  localparam logic [1:0] RegTileLength = 2'd0;
  localparam logic [1:0] RegLodShift   = 2'd1;
  localparam logic [1:0] RegTileGridX  = 2'd2;
  localparam logic [1:0] RegTileGridZ  = 2'd3;

  localparam logic [8:0] TileLengthRst = 9'd64;

  // Bits of a normal component magnitude found by the normaliser, one per step.
  localparam int unsigned NormSteps = 16;
  localparam logic [15:0] NormOne   = 16'h7FFF;

endpackage

FILE: design/heightmap_vertex_normal_generator.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normal generator
// Turns a raster stream of terrain heights into mesh vertices with position,
// texture coordinates and a central difference unit normal.
// ----------------------------------------------------------------------------
// Heights arrive row by row; from the second row on, the vertex one row up is
// emitted for each sample, and on the last row the sample's own vertex follows
// it. The front end stalls its input until it is through with a sample: two
// reads of the row stores' read ports, one write and up to two queue pushes,
// each push waiting while the queue is full. In the back end each inner vertex
// passes through the sixteen-step bit-serial normaliser; border vertices skip
// it. A two-entry queue lets the front end keep taking samples while the back
// end works and while a finished vertex waits in the output register.
module heightmap_vertex_normal_generator #(
  parameter int unsigned MAX_SIDE    = 256,
  parameter int unsigned HEIGHT_BITS = 16,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        height_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         vertex_row_o,
  output logic [7:0]         vertex_col_o,
  output logic [23:0]        world_x_o,
  output logic [15:0]        world_y_o,
  output logic [23:0]        world_z_o,
  output logic [15:0]        tex_u_o,
  output logic [15:0]        tex_v_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic               run_end_o
);

  localparam int unsigned AW = $clog2(MAX_SIDE);
  localparam int unsigned HW = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;
  localparam int unsigned EW = 2 * AW + 3 * HW + 4;

  hvng_pkg::cfg_t cfg_q;
  logic           push, pop, full, empty;
  logic [EW-1:0]  wdata, rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_length <= hvng_pkg::TileLengthRst;
      cfg_q.lod_shift   <= '0;
      cfg_q.tile_grid_x <= '0;
      cfg_q.tile_grid_z <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hvng_pkg::RegTileLength: cfg_q.tile_length <= cfg_data_i;
        hvng_pkg::RegLodShift:   cfg_q.lod_shift   <= cfg_data_i[1:0];
        hvng_pkg::RegTileGridX:  cfg_q.tile_grid_x <= cfg_data_i[7:0];
        hvng_pkg::RegTileGridZ:  cfg_q.tile_grid_z <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  hvng_front #(.MAX_SIDE(MAX_SIDE), .HEIGHT_BITS(HEIGHT_BITS), .EW(EW)) u_front (
    .clk_i, .rst_ni,
    .cfg_i           (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .height_sample_i,
    .push_o          (push),
    .entry_o         (wdata),
    .full_i          (full)
  );

  hvng_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rdata),
    .empty_o (empty)
  );

  hvng_back #(.MAX_SIDE(MAX_SIDE), .HEIGHT_BITS(HEIGHT_BITS), .EW(EW)) u_back (
    .clk_i, .rst_ni,
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .pop_o   (pop),
    .entry_i (rdata),
    .out_valid_o,
    .out_stall_i,
    .vertex_row_o,
    .vertex_col_o,
    .world_x_o,
    .world_y_o,
    .world_z_o,
    .tex_u_o,
    .tex_v_o,
    .normal_x_o,
    .normal_y_o,
    .normal_z_o,
    .run_end_o
  );

endmodule

FILE: design/hvng_fifo.sv
// ----------------------------------------------------------------------------
// Vertex job queue
// Short first-in first-out queue between the sample front end and the vertex
// back end.
// ----------------------------------------------------------------------------
module hvng_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH)) else $error("queue fill count out of range");
`endif

endmodule

FILE: design/hvng_front.sv
// ----------------------------------------------------------------------------
// Sample front end
// Tracks the raster position, keeps the two row stores and turns each height
// sample into zero, one or two vertex jobs for the back end.
// ----------------------------------------------------------------------------
module hvng_front #(
  parameter int unsigned MAX_SIDE    = 256,
  parameter int unsigned HEIGHT_BITS = 16,
  parameter int unsigned EW          = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hvng_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [15:0]       height_sample_i,
  output logic              push_o,
  output logic [EW-1:0]     entry_o,
  input  logic              full_i
);

  localparam int unsigned AW = $clog2(MAX_SIDE);
  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned HW = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;

  typedef struct packed {
    logic [AW-1:0]        row;
    logic [AW-1:0]        col;
    logic [HW-1:0]        height;
    logic signed [HW:0]   diff_a;
    logic signed [HW:0]   diff_c;
    logic                 border;
    logic                 run_end;
  } entry_t;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRd0  = 3'd1;
  localparam logic [2:0] StRd1  = 3'd2;
  localparam logic [2:0] StRd2  = 3'd3;
  localparam logic [2:0] StPsh0 = 3'd4;
  localparam logic [2:0] StPsh1 = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] row_q, row_d, col_q, col_d;
  logic [HW-1:0] h_q;
  logic [HW-1:0] older_mem [MAX_SIDE];
  logic [HW-1:0] newer_mem [MAX_SIDE];
  logic [AW-1:0] old_addr, new_addr;
  logic [HW-1:0] old_rd_q, new_rd_q;
  logic [HW-1:0] old_z_q, center_q;
  logic          mem_we;
  entry_t        e0_q, e1_q, e0_d, e1_d;
  logic          need0_q, need1_q;
  logic [11:0]   side_raw;
  logic [SW-1:0] side;
  logic [SW-1:0] col_next, row_next;
  logic          accept;
  logic          border0;

  assign side_raw = {3'b000, cfg_i.tile_length} << cfg_i.lod_shift;

  always_comb begin
    if (side_raw < 12'd2) begin
      side = SW'(2);
    end else if (side_raw > 12'(MAX_SIDE)) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = SW'(side_raw);
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign mem_we     = (state_q == StRd2);

  // The first read fetches the centre column, the second the diagonal neighbours.
  assign old_addr = (state_q == StRd1) ? col_q - 1'b1 : col_q;
  assign new_addr = (state_q == StRd1) ? col_q + 1'b1 : col_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      older_mem[col_q] <= center_q;
    end
    old_rd_q <= older_mem[old_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      newer_mem[col_q] <= h_q;
    end
    new_rd_q <= newer_mem[new_addr];
  end

  assign col_next = SW'(col_q) + 1'b1;
  assign row_next = SW'(row_q) + 1'b1;
  assign border0  = (row_q == AW'(1)) || (col_q == '0) || (SW'(col_q) == side - 1'b1);

  always_comb begin
    e0_d         = '0;
    e0_d.row     = row_q - 1'b1;
    e0_d.col     = col_q;
    e0_d.height  = center_q;
    e0_d.border  = border0;
    e0_d.run_end = (SW'(row_q) != side - 1'b1);
    if (!border0) begin
      e0_d.diff_a = $signed({1'b0, old_z_q}) - $signed({1'b0, h_q});
      e0_d.diff_c = $signed({1'b0, old_rd_q}) - $signed({1'b0, new_rd_q});
    end
  end

  always_comb begin
    e1_d         = '0;
    e1_d.row     = row_q;
    e1_d.col     = col_q;
    e1_d.height  = h_q;
    e1_d.border  = 1'b1;
    e1_d.run_end = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    push_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRd0;
          // A side shrunk by a register write restarts the tile.
          if (SW'(row_q) >= side || SW'(col_q) >= side) begin
            row_d = '0;
            col_d = '0;
          end
        end
      end
      StRd0: state_d = StRd1;
      StRd1: state_d = StRd2;
      StRd2: begin
        state_d = StPsh0;
        if (col_next >= side) begin
          col_d = '0;
          row_d = (row_next >= side) ? '0 : AW'(row_next);
        end else begin
          col_d = AW'(col_next);
        end
      end
      StPsh0: begin
        if (!need0_q || !full_i) begin
          push_o  = need0_q;
          state_d = StPsh1;
        end
      end
      StPsh1: begin
        if (!need1_q || !full_i) begin
          push_o  = need1_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign entry_o = (state_q == StPsh0) ? e0_q : e1_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      h_q <= height_sample_i[HW-1:0];
    end
    if (state_q == StRd1) begin
      old_z_q  <= old_rd_q;
      center_q <= new_rd_q;
    end
    if (state_q == StRd2) begin
      e0_q <= e0_d;
      e1_q <= e1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q   <= '0;
      col_q   <= '0;
      need0_q <= 1'b0;
      need1_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      if (state_q == StRd2) begin
        need0_q <= (row_q != '0);
        need1_q <= (SW'(row_q) == side - 1'b1);
      end
    end
  end

endmodule

FILE: design/hvng_nrm.sv
// ----------------------------------------------------------------------------
// Normal component normaliser lane
// Finds round(m * 2^15 / sqrt(S)) one bit a cycle while step_i is high, most
// significant first, with shift-and-add updates of the squared trial value.
// ----------------------------------------------------------------------------
module hvng_nrm #(
  parameter int unsigned SSW = 38,
  parameter int unsigned SQW = 36
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           step_i,
  input  logic [SSW-1:0]                 s_i,
  input  logic [SQW-1:0]                 msq_i,
  output logic [hvng_pkg::NormSteps-1:0] mag_o
);

  localparam int unsigned NS = hvng_pkg::NormSteps;
  localparam int unsigned PW = SSW + 2 * NS + 4;

  // With t = 2*mag - 1, p holds t^2*S, r holds t*S*2^(k+2) and w holds
  // S*2^(2k+2) for the bit k under trial.
  logic signed [PW-1:0] p_q, r_q, w_q;
  logic signed [PW-1:0] m_lim, p_c, r_upd;
  logic [NS-1:0]        mag_q;
  logic                 take;

  assign m_lim = $signed(PW'(msq_i) << (2 * NS));
  assign p_c   = p_q + r_q + w_q;
  assign take  = (p_c <= m_lim);
  assign r_upd = take ? (r_q + (w_q <<< 1)) : r_q;
  assign mag_o = mag_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= $signed(PW'(s_i));
      r_q <= -($signed(PW'(s_i)) <<< (NS + 1));
      w_q <= $signed(PW'(s_i) << (2 * NS));
    end else if (step_i) begin
      if (take) begin
        p_q <= p_c;
      end
      r_q <= r_upd >>> 1;
      w_q <= w_q >>> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= '0;
    end else if (start_i) begin
      mag_q <= '0;
    end else if (step_i) begin
      mag_q <= {mag_q[NS-2:0], take};
    end
  end

endmodule

FILE: design/hvng_back.sv
// ----------------------------------------------------------------------------
// Vertex back end
// Takes vertex jobs from the queue, works out position and texture coordinates,
// normalises the central difference normal and holds the result for output.
// ----------------------------------------------------------------------------
module hvng_back #(
  parameter int unsigned MAX_SIDE    = 256,
  parameter int unsigned HEIGHT_BITS = 16,
  parameter int unsigned EW          = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hvng_pkg::cfg_t     cfg_i,
  input  logic               empty_i,
  output logic               pop_o,
  input  logic [EW-1:0]      entry_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         vertex_row_o,
  output logic [7:0]         vertex_col_o,
  output logic [23:0]        world_x_o,
  output logic [15:0]        world_y_o,
  output logic [23:0]        world_z_o,
  output logic [15:0]        tex_u_o,
  output logic [15:0]        tex_v_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic               run_end_o
);

  localparam int unsigned AW  = $clog2(MAX_SIDE);
  localparam int unsigned HW  = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;
  localparam int unsigned DW  = HEIGHT_BITS + 2;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned SSW = 2 * DW + 2;
  localparam int unsigned NS  = hvng_pkg::NormSteps;
  localparam int unsigned StW = $clog2(NS);
  localparam int unsigned PSW = ((AW + 8 > 25) ? AW + 8 : 25) + 1;
  localparam int unsigned TW  = AW + 8;

  localparam logic [SQW-1:0] SqB = SQW'(1) << (2 * HEIGHT_BITS + 2);

  typedef struct packed {
    logic [AW-1:0]        row;
    logic [AW-1:0]        col;
    logic [HW-1:0]        height;
    logic signed [HW:0]   diff_a;
    logic signed [HW:0]   diff_c;
    logic                 border;
    logic                 run_end;
  } entry_t;

  localparam logic [2:0] BIdle = 3'd0;
  localparam logic [2:0] BSq   = 3'd1;
  localparam logic [2:0] BSum  = 3'd2;
  localparam logic [2:0] BIni  = 3'd3;
  localparam logic [2:0] BIter = 3'd4;
  localparam logic [2:0] BFin  = 3'd5;

  logic [2:0]     state_q, state_d;
  entry_t         ent_q;
  logic [HW:0]    abs_a, abs_c;
  logic [DW-1:0]  mag_a, mag_c;
  logic [SQW-1:0] sq_a_q, sq_c_q;
  logic [SSW-1:0] s_q;
  logic [16:0]    prod_x_q, prod_z_q;
  logic [StW-1:0] step_q;
  logic [NS-1:0]  lane_a, lane_b, lane_c;
  logic           load_out;
  logic           out_valid_q;

  logic [7:0]  row_q, col_q;
  logic [23:0] wx_q, wz_q;
  logic [15:0] wy_q, tu_q, tv_q, nx_q, ny_q, nz_q;
  logic        end_q;

  function automatic logic [23:0] world_q8(logic [AW-1:0] idx, logic [7:0] grid,
                                           logic [16:0] prod, logic [1:0] lod);
    logic [PSW-1:0] plus;
    logic [PSW-1:0] minus;
    logic [PSW-1:0] v;
    plus  = (PSW'(prod) << 8) + (PSW'(idx) << (4'd8 - {2'b00, lod}));
    minus = PSW'(grid) << (4'd8 - {2'b00, lod});
    v     = (minus > plus) ? '0 : plus - minus;
    return (v > PSW'(24'hFFFFFF)) ? 24'hFFFFFF : v[23:0];
  endfunction

  function automatic logic [15:0] tex_q8(logic [AW-1:0] idx, logic [1:0] lod);
    logic [TW-1:0] t;
    t = TW'(idx) << (4'd8 - {2'b00, lod});
    return (t > TW'(16'hFFFF)) ? 16'hFFFF : 16'(t);
  endfunction

  // A negative component takes the two's complement of the magnitude; a
  // positive one saturates at +1.
  function automatic logic [15:0] comp_q15(logic neg, logic [NS-1:0] mag);
    logic [15:0] m16;
    m16 = 16'(mag);
    if (neg) begin
      return ~m16 + 1'b1;
    end
    return (m16 > hvng_pkg::NormOne) ? hvng_pkg::NormOne : m16;
  endfunction

  assign abs_a = ent_q.diff_a[HW] ? (~ent_q.diff_a + 1'b1) : ent_q.diff_a;
  assign abs_c = ent_q.diff_c[HW] ? (~ent_q.diff_c + 1'b1) : ent_q.diff_c;
  assign mag_a = DW'(abs_a);
  assign mag_c = DW'(abs_c);

  hvng_nrm #(.SSW(SSW), .SQW(SQW)) u_nrm_x (
    .clk_i, .rst_ni,
    .start_i (state_q == BIni),
    .step_i  (state_q == BIter),
    .s_i     (s_q),
    .msq_i   (sq_a_q),
    .mag_o   (lane_a)
  );

  hvng_nrm #(.SSW(SSW), .SQW(SQW)) u_nrm_y (
    .clk_i, .rst_ni,
    .start_i (state_q == BIni),
    .step_i  (state_q == BIter),
    .s_i     (s_q),
    .msq_i   (SqB),
    .mag_o   (lane_b)
  );

  hvng_nrm #(.SSW(SSW), .SQW(SQW)) u_nrm_z (
    .clk_i, .rst_ni,
    .start_i (state_q == BIni),
    .step_i  (state_q == BIter),
    .s_i     (s_q),
    .msq_i   (sq_c_q),
    .mag_o   (lane_c)
  );

  assign load_out = (state_q == BFin) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      BIdle: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BSq;
        end
      end
      BSq:   state_d = ent_q.border ? BFin : BSum;
      BSum:  state_d = BIni;
      BIni:  state_d = BIter;
      BIter: begin
        if (step_q == StW'(NS - 1)) begin
          state_d = BFin;
        end
      end
      BFin: begin
        if (load_out) begin
          state_d = BIdle;
        end
      end
      default: state_d = BIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= entry_t'(entry_i);
    end
    if (state_q == BSq) begin
      sq_a_q   <= mag_a * mag_a;
      sq_c_q   <= mag_c * mag_c;
      prod_x_q <= cfg_i.tile_grid_x * cfg_i.tile_length;
      prod_z_q <= cfg_i.tile_grid_z * cfg_i.tile_length;
    end
    if (state_q == BSum) begin
      s_q <= SSW'(sq_a_q) + SSW'(SqB) + SSW'(sq_c_q);
    end
    if (load_out) begin
      row_q <= 8'(ent_q.row);
      col_q <= 8'(ent_q.col);
      wx_q  <= world_q8(ent_q.row, cfg_i.tile_grid_x, prod_x_q, cfg_i.lod_shift);
      wz_q  <= world_q8(ent_q.col, cfg_i.tile_grid_z, prod_z_q, cfg_i.lod_shift);
      wy_q  <= 16'(ent_q.height);
      tu_q  <= tex_q8(ent_q.row, cfg_i.lod_shift);
      tv_q  <= tex_q8(ent_q.col, cfg_i.lod_shift);
      end_q <= ent_q.run_end;
      if (ent_q.border) begin
        nx_q <= '0;
        ny_q <= hvng_pkg::NormOne;
        nz_q <= '0;
      end else begin
        nx_q <= comp_q15(ent_q.diff_a[HW], lane_a);
        ny_q <= comp_q15(1'b0, lane_b);
        nz_q <= comp_q15(ent_q.diff_c[HW], lane_c);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BIter) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vertex_row_o = row_q;
  assign vertex_col_o = col_q;
  assign world_x_o    = wx_q;
  assign world_y_o    = wy_q;
  assign world_z_o    = wz_q;
  assign tex_u_o      = tu_q;
  assign tex_v_o      = tv_q;
  assign normal_x_o   = $signed(nx_q);
  assign normal_y_o   = $signed(ny_q);
  assign normal_z_o   = $signed(nz_q);
  assign run_end_o    = end_q;

endmodule

FILE: tb/sv/tb_heightmap_vertex_normal_generator.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normal generator testbench
// Streams tiles of height samples through the block under several register
// settings and idling patterns. A cycle-free predictor computes each vertex
// and the checker compares every emitted vertex with it, field by field.
// ----------------------------------------------------------------------------
module tb_heightmap_vertex_normal_generator;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [23:0] wx;
    logic [15:0] wy;
    logic [23:0] wz;
    logic [15:0] tu;
    logic [15:0] tv;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        last;
  } vertex_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [15:0] height_q = '0;
  logic        out_stall = 1'b0;
  logic        cfg_ready_o, in_stall_o, out_valid_o, run_end_o;
  logic [7:0]  vertex_row_o, vertex_col_o;
  logic [23:0] world_x_o, world_z_o;
  logic [15:0] world_y_o, tex_u_o, tex_v_o;
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;

  // Shadow registers and grid state of the predictor.
  logic [8:0]  sh_tile_len = hvng_pkg::TileLengthRst;
  logic [1:0]  sh_lod = '0;
  logic [7:0]  sh_grid_x = '0;
  logic [7:0]  sh_grid_z = '0;
  logic [15:0] prev_row [256];
  logic [15:0] last_row [256];
  int unsigned cur_row = 0;
  int unsigned cur_col = 0;

  logic [15:0] pending_heights [$];
  vertex_t     expected_vertices [$];
  int          errors = 0;
  int          samples_taken = 0;
  int          vertices_seen = 0;
  int          tiles_run = 0;
  int          idle_mode = 0;
  bit          hold_request = 1'b0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  heightmap_vertex_normal_generator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .height_sample_i(height_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .vertex_row_o   (vertex_row_o),
    .vertex_col_o   (vertex_col_o),
    .world_x_o      (world_x_o),
    .world_y_o      (world_y_o),
    .world_z_o      (world_z_o),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .run_end_o      (run_end_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned grid_side();
    int unsigned s;
    s = int'(sh_tile_len) << sh_lod;
    if (s < 2) s = 2;
    if (s > 256) s = 256;
    return s;
  endfunction

  function automatic logic [23:0] world_coord(int unsigned idx, logic [7:0] grid);
    longint plus, minus, v;
    plus  = longint'(grid) * longint'(sh_tile_len) * 256 + (longint'(idx) << (8 - sh_lod));
    minus = longint'(grid) << (8 - sh_lod);
    v = (minus > plus) ? 0 : plus - minus;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return v[23:0];
  endfunction

  function automatic logic [15:0] tex_coord(int unsigned idx);
    longint v;
    v = longint'(idx) << (8 - sh_lod);
    if (v > 16'hFFFF) v = 16'hFFFF;
    return v[15:0];
  endfunction

  // Largest m with (m - 1/2) <= |v| * 2^15 / sqrt(ss), giving round half away.
  function automatic logic [15:0] unit_component(longint v, logic [127:0] ss);
    longint       mag, t;
    logic [127:0] lhs, rhs;
    int unsigned  lo, hi, mid;
    mag = (v < 0) ? -v : v;
    rhs = 128'(mag * mag) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 2 * longint'(mid) - 1;
      lhs = 128'(t * t) * ss;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (v < 0) return 16'((65536 - lo) & 16'hFFFF);
    return (lo > 32767) ? hvng_pkg::NormOne : 16'(lo);
  endfunction

  function automatic vertex_t make_vertex(int unsigned x, int unsigned z, logic [15:0] h,
                                          logic [15:0] nx, logic [15:0] ny,
                                          logic [15:0] nz, logic last);
    vertex_t r;
    r.row = x[7:0];
    r.col = z[7:0];
    r.wx = world_coord(x, sh_grid_x);
    r.wy = h;
    r.wz = world_coord(z, sh_grid_z);
    r.tu = tex_coord(x);
    r.tv = tex_coord(z);
    r.nx = nx;
    r.ny = ny;
    r.nz = nz;
    r.last = last;
    return r;
  endfunction

  task automatic add_height(logic [15:0] h);
    pending_heights.insert(pending_heights.size(), h);
  endtask

  task automatic add_vertex(vertex_t v);
    expected_vertices.insert(expected_vertices.size(), v);
  endtask

  task automatic predict_vertices(logic [15:0] h);
    int unsigned  side;
    longint       dx, dz, dy;
    logic [127:0] ss;
    logic [15:0]  nx, ny, nz;
    side = grid_side();
    if (cur_row >= side || cur_col >= side) begin
      cur_row = 0;
      cur_col = 0;
    end
    if (cur_row >= 1) begin
      nx = '0;
      ny = hvng_pkg::NormOne;
      nz = '0;
      if (!(cur_row == 1 || cur_col == 0 || cur_col == side - 1)) begin
        dx = longint'(prev_row[cur_col]) - longint'(h);
        dz = longint'(prev_row[cur_col-1]) - longint'(last_row[cur_col+1]);
        dy = longint'(2) << 16;
        ss = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
        nx = unit_component(dx, ss);
        ny = unit_component(dy, ss);
        nz = unit_component(dz, ss);
      end
      add_vertex(make_vertex(cur_row - 1, cur_col, last_row[cur_col],
                             nx, ny, nz, cur_row != side - 1));
    end
    if (cur_row == side - 1)
      add_vertex(make_vertex(cur_row, cur_col, h, '0, hvng_pkg::NormOne, '0, 1'b1));
    prev_row[cur_col] = last_row[cur_col];
    last_row[cur_col] = h;
    cur_col++;
    if (cur_col >= side) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= side) cur_row = 0;
    end
  endtask

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Sample driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predict_vertices(height_q);
        samples_taken++;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_heights.size() != 0 &&
            !((idle_mode == 1 && $urandom_range(99) < 59) ||
              (idle_mode == 3 && $urandom_range(99) < 33))) begin
          in_valid <= 1'b1;
          height_q <= pending_heights.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Vertex monitor, receiver stalls and watchdog.
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t w;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        vertices_seen++;
        if (expected_vertices.size() == 0) begin
          report("vertex with none pending", {vertex_row_o, vertex_col_o}, 0);
        end else begin
          w = expected_vertices.pop_front();
          if (vertex_row_o !== w.row) report("vertex_row", vertex_row_o, w.row);
          if (vertex_col_o !== w.col) report("vertex_col", vertex_col_o, w.col);
          if (world_x_o !== w.wx) report("world_x", world_x_o, w.wx);
          if (world_y_o !== w.wy) report("world_y", world_y_o, w.wy);
          if (world_z_o !== w.wz) report("world_z", world_z_o, w.wz);
          if (tex_u_o !== w.tu) report("tex_u", tex_u_o, w.tu);
          if (tex_v_o !== w.tv) report("tex_v", tex_v_o, w.tv);
          if (normal_x_o !== w.nx) report("normal_x", normal_x_o, w.nx);
          if (normal_y_o !== w.ny) report("normal_y", normal_y_o, w.ny);
          if (normal_z_o !== w.nz) report("normal_z", normal_z_o, w.nz);
          if (run_end_o !== w.last) report("run_end", run_end_o, w.last);
        end
      end
      if ((out_valid_o && !out_stall) || (in_valid && !in_stall_o) ||
          (cfg_valid && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 5000) begin
        $display("Verification failed");
        $finish;
      end
      if (hold_request && hold_cnt == 0) begin
        hold_request = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (idle_mode == 2 && $urandom_range(99) < 59) ||
                     (idle_mode == 3 && $urandom_range(99) < 33);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [8:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      hvng_pkg::RegTileLength: sh_tile_len = value;
      hvng_pkg::RegLodShift:   sh_lod = value[1:0];
      hvng_pkg::RegTileGridX:  sh_grid_x = value[7:0];
      hvng_pkg::RegTileGridZ:  sh_grid_z = value[7:0];
      default: ;
    endcase
  endtask

  // Waits until every vertex has arrived, then lets the back end settle.
  task automatic drain();
    while (pending_heights.size() != 0 || in_valid || expected_vertices.size() != 0)
      @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic setup(logic [8:0] tl, logic [1:0] lod, logic [7:0] gx, logic [7:0] gz);
    write_reg(hvng_pkg::RegTileLength, tl);
    write_reg(hvng_pkg::RegLodShift, {7'd0, lod});
    write_reg(hvng_pkg::RegTileGridX, {1'b0, gx});
    write_reg(hvng_pkg::RegTileGridZ, {1'b0, gz});
  endtask

  function automatic logic [15:0] random_height();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned side, lod, tl;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: the smallest grid, then a side-4 tile of alternating extreme heights.
    setup(9'd2, 2'd0, 8'd0, 8'd0);
    repeat (4) add_height(16'hFFFF);
    drain();
    setup(9'd4, 2'd0, 8'd255, 8'd255);
    for (int i = 0; i < 16; i++)
      add_height(((i + i / 4) % 2) ? 16'hFFFF : 16'h0000);
    drain();
    tiles_run = 2;

    // Oversized tile length clamps the side to the store depth; two rows only.
    // The receiver holds off meanwhile, so the block backs up onto its input.
    setup(9'd511, 2'd3, 8'd255, 8'd0);
    for (int i = 0; i < 512; i++) add_height(random_height());
    while (samples_taken < 20 + 300) @(posedge clk_i);
    hold_request = 1'b1;
    drain();
    // Shrinking the side now leaves the counters outside it, so the next tile restarts.
    setup(9'd1, 2'd0, 8'd17, 8'd255);
    repeat (4) add_height(random_height());
    drain();
    tiles_run += 2;

    while (samples_taken < 1900) begin
      idle_mode = tiles_run % 4;
      lod = $urandom_range(3);
      tl = $urandom_range(16 >> lod);
      side = tl << lod;
      if (side < 2) side = 2;
      setup(9'(tl), 2'(lod), 8'($urandom), ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom));
      for (int i = 0; i < side * side; i++) add_height(random_height());
      drain();
      tiles_run++;
    end

    $display("%0d tiles, %0d height samples and %0d vertices checked,", tiles_run,
             samples_taken, vertices_seen);
    $display("side from 2 to 256, every level of detail, grid offsets 0 to 255.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/hvng_pkg.sv
design/hvng_fifo.sv
design/hvng_front.sv
design/hvng_nrm.sv
design/hvng_back.sv
design/heightmap_vertex_normal_generator.sv
tb/sv/tb_heightmap_vertex_normal_generator.sv
